[design/spmp_pkg.sv]
// shared types and constants for the scatter point to pixel mapper
package spmp_pkg;

    // default screen geometry
    localparam int SCREEN_MAX_DEF = 127;
    localparam int Y_OFFSET_DEF   = 30;

    // field widths
    localparam int PT_W     = 32;
    localparam int CFG_W    = 18;
    localparam int PIX_X_W  = 7;
    localparam int PIX_Y_W  = 8;
    localparam int CFG_IDX_W = 2;

    // four pixels per kept point, so the input holds off after each kept point
    localparam int HOLD_W = 2;
    localparam logic [HOLD_W-1:0] HOLD_KEPT = 2'd3;

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MIN_X = 2'd0;
    localparam t_cfg_idx CFG_MAX_X = 2'd1;
    localparam t_cfg_idx CFG_MIN_Y = 2'd2;
    localparam t_cfg_idx CFG_MAX_Y = 2'd3;

    // register reset values
    localparam logic signed [CFG_W-1:0] MIN_X_RST = 18'sd0;
    localparam logic signed [CFG_W-1:0] MAX_X_RST = 18'sd1000;
    localparam logic signed [CFG_W-1:0] MIN_Y_RST = 18'sd0;
    localparam logic signed [CFG_W-1:0] MAX_Y_RST = 18'sd1000;

    // control that travels alongside each point through the cells
    typedef struct packed {
        logic valid;
        logic keep;
        logic last;
    } t_tag;

endpackage

[design/spmp_cell.sv]
// one divider cell: settles one quotient bit of x and of y per clock
module spmp_cell
    import spmp_pkg::*;
#(
    parameter int DW  = CFG_W,
    parameter int QW  = 7,
    parameter int BIT = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_tag               i_tag,
    input  logic [DW+QW-1:0]   i_rem_x,
    input  logic [DW+QW-1:0]   i_rem_y,
    input  logic [DW-1:0]      i_div_x,
    input  logic [DW-1:0]      i_div_y,
    input  logic [QW-1:0]      i_quo_x,
    input  logic [QW-1:0]      i_quo_y,
    output t_tag               o_tag,
    output logic [DW+QW-1:0]   o_rem_x,
    output logic [DW+QW-1:0]   o_rem_y,
    output logic [DW-1:0]      o_div_x,
    output logic [DW-1:0]      o_div_y,
    output logic [QW-1:0]      o_quo_x,
    output logic [QW-1:0]      o_quo_y
);

    localparam int NW = DW + QW;

    t_tag            r_tag;
    logic [NW-1:0]   r_rem_x, r_rem_y, n_rem_x, n_rem_y;
    logic [DW-1:0]   r_div_x, r_div_y;
    logic [QW-1:0]   r_quo_x, r_quo_y, n_quo_x, n_quo_y;
    logic [NW-1:0]   sh_x, sh_y;
    logic            ge_x, ge_y;

    // trial subtract of the divisor at this bit weight
    always_comb begin
        sh_x    = NW'(i_div_x) << BIT;
        sh_y    = NW'(i_div_y) << BIT;
        ge_x    = (i_rem_x >= sh_x);
        ge_y    = (i_rem_y >= sh_y);
        n_rem_x = ge_x ? (i_rem_x - sh_x) : i_rem_x;
        n_rem_y = ge_y ? (i_rem_y - sh_y) : i_rem_y;
        n_quo_x = i_quo_x;
        n_quo_y = i_quo_y;
        n_quo_x[BIT] = ge_x;
        n_quo_y[BIT] = ge_y;
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rem_x <= n_rem_x;
        r_rem_y <= n_rem_y;
        r_div_x <= i_div_x;
        r_div_y <= i_div_y;
        r_quo_x <= n_quo_x;
        r_quo_y <= n_quo_y;
    end

    assign o_tag   = r_tag;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_div_x = r_div_x;
    assign o_div_y = r_div_y;
    assign o_quo_x = r_quo_x;
    assign o_quo_y = r_quo_y;

endmodule

[design/spmp_emit.sv]
// pixel emitter: forms the four neighbour pixels and sends one word per cycle
module spmp_emit
    import spmp_pkg::*;
#(
    parameter int SCREEN_MAX = SCREEN_MAX_DEF,
    parameter int Y_OFFSET   = Y_OFFSET_DEF,
    parameter int QW         = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_tag               i_tag,
    input  logic [QW-1:0]      i_quo_x,
    input  logic [QW-1:0]      i_quo_y,
    output logic               o_strobe,
    output logic [PIX_X_W-1:0] o_pixel_x,
    output logic [PIX_Y_W-1:0] o_pixel_y,
    output logic               o_pixel_valid,
    output logic               o_last_of_point,
    output logic               o_plot_done
);

    localparam int PYW = $clog2(SCREEN_MAX + Y_OFFSET + 2);
    localparam int CW  = (PYW + 1 > PIX_Y_W) ? PYW + 1 : PIX_Y_W;

    // emit step codes
    localparam logic [1:0] STEP_IDLE  = 2'd0;
    localparam logic [1:0] STEP_DIAG  = 2'd1;
    localparam logic [1:0] STEP_RIGHT = 2'd2;
    localparam logic [1:0] STEP_LOWER = 2'd3;

    logic [1:0]    r_step, n_step;
    logic          r_last, n_last;
    logic [CW-1:0] r_px, r_py, r_rx, r_ly;
    logic [CW-1:0] c_px, c_py, c_rx, c_ly;
    logic          r_strobe, n_strobe;
    logic [CW-1:0] r_pix_x, n_pix_x, r_pix_y, n_pix_y;
    logic          r_pix_valid, n_pix_valid;
    logic          r_last_of_point, n_last_of_point;
    logic          r_plot_done, n_plot_done;

    // flip and offset the row, step to the neighbour column and row
    always_comb begin
        c_px = CW'(i_quo_x);
        c_py = CW'(SCREEN_MAX) - CW'(i_quo_y) + CW'(Y_OFFSET);
        c_rx = (c_px + CW'(1) <= CW'(SCREEN_MAX)) ? c_px + CW'(1) : c_px - CW'(1);
        c_ly = (c_py + CW'(1) <= CW'(SCREEN_MAX)) ? c_py + CW'(1) : c_py - CW'(1);
    end

    // word sequencing
    always_comb begin
        n_step          = r_step;
        n_last          = r_last;
        n_strobe        = 1'b0;
        n_pix_x         = '0;
        n_pix_y         = '0;
        n_pix_valid     = 1'b0;
        n_last_of_point = 1'b0;
        n_plot_done     = 1'b0;
        unique case (r_step)
            STEP_IDLE: begin
                if (i_tag.valid && i_tag.keep) begin
                    n_strobe    = 1'b1;
                    n_pix_x     = c_px;
                    n_pix_y     = c_py;
                    n_pix_valid = 1'b1;
                    n_last      = i_tag.last;
                    n_step      = STEP_DIAG;
                end else if (i_tag.valid && i_tag.last) begin
                    // dropped final point: end marker only
                    n_strobe        = 1'b1;
                    n_last_of_point = 1'b1;
                    n_plot_done     = 1'b1;
                end
            end
            STEP_DIAG: begin
                n_strobe    = 1'b1;
                n_pix_x     = r_rx;
                n_pix_y     = r_ly;
                n_pix_valid = 1'b1;
                n_step      = STEP_RIGHT;
            end
            STEP_RIGHT: begin
                n_strobe    = 1'b1;
                n_pix_x     = r_rx;
                n_pix_y     = r_py;
                n_pix_valid = 1'b1;
                n_step      = STEP_LOWER;
            end
            STEP_LOWER: begin
                n_strobe        = 1'b1;
                n_pix_x         = r_px;
                n_pix_y         = r_ly;
                n_pix_valid     = 1'b1;
                n_last_of_point = 1'b1;
                n_plot_done     = r_last;
                n_step          = STEP_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= STEP_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_step   <= n_step;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_last          <= n_last;
        r_pix_x         <= n_pix_x;
        r_pix_y         <= n_pix_y;
        r_pix_valid     <= n_pix_valid;
        r_last_of_point <= n_last_of_point;
        r_plot_done     <= n_plot_done;
        if (r_step == STEP_IDLE) begin
            r_px <= c_px;
            r_py <= c_py;
            r_rx <= c_rx;
            r_ly <= c_ly;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_pixel_x       = r_pix_x[PIX_X_W-1:0];
    assign o_pixel_y       = r_pix_y[PIX_Y_W-1:0];
    assign o_pixel_valid   = r_pix_valid;
    assign o_last_of_point = r_last_of_point;
    assign o_plot_done     = r_plot_done;

endmodule

[design/scatter_point_to_pixel_mapper.sv]
// top level: bounds check, constant scaling, divider cell chain and pixel emitter
//
// A point is taken when start is high and busy is low. Points outside the
// configured bounds, or on an axis whose range has zero width, are dropped
// without holding off the input; a dropped point with last_point set gives a
// single end-marker word. A kept point gives four pixel words on consecutive
// cycles, and busy stays high after it is taken until r_hold counts down, so
// one dropped point can be taken every cycle but a kept point holds off the next.
// The scaling divide runs through a chain of clog2(SCREEN_MAX+1) cells, one
// quotient bit each, so the first word of a point passes the input registers,
// the cells and the emitter's output register before it comes out.
// Words are strobed for exactly one cycle and cannot be held off. The
// configuration port is always ready; write it only while no point is in flight.
module scatter_point_to_pixel_mapper
    import spmp_pkg::*;
#(
    parameter int SCREEN_MAX = SCREEN_MAX_DEF,
    parameter int Y_OFFSET   = Y_OFFSET_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // point channel
    input  logic                    start,
    output logic                    busy,
    input  logic signed [PT_W-1:0]  i_point_x,
    input  logic signed [PT_W-1:0]  i_point_y,
    input  logic                    i_last_point,
    // pixel channel
    output logic                    o_strobe,
    output logic [PIX_X_W-1:0]      o_pixel_x,
    output logic [PIX_Y_W-1:0]      o_pixel_y,
    output logic                    o_pixel_valid,
    output logic                    o_last_of_point,
    output logic                    o_plot_done,
    // configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  t_cfg_idx                i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    localparam int DW = CFG_W;
    localparam int QW = $clog2(SCREEN_MAX + 1);
    localparam int NW = DW + QW;

    logic signed [CFG_W-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic [HOLD_W-1:0]       r_hold, n_hold;
    logic                    accept, keep;
    t_tag                    r_tag, n_tag;
    logic [DW-1:0]           r_dx, r_dy, r_rng_x, r_rng_y;

    t_tag                    tag_c   [QW+1];
    logic [NW-1:0]           rem_x_c [QW+1];
    logic [NW-1:0]           rem_y_c [QW+1];
    logic [DW-1:0]           div_x_c [QW+1];
    logic [DW-1:0]           div_y_c [QW+1];
    logic [QW-1:0]           quo_x_c [QW+1];
    logic [QW-1:0]           quo_y_c [QW+1];

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= MIN_X_RST;
            r_max_x <= MAX_X_RST;
            r_min_y <= MIN_Y_RST;
            r_max_y <= MAX_Y_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_X: r_min_x <= i_cfg_data;
                CFG_MAX_X: r_max_x <= i_cfg_data;
                CFG_MIN_Y: r_min_y <= i_cfg_data;
                CFG_MAX_Y: r_max_y <= i_cfg_data;
            endcase
        end
    end

    // bounds check and input hold-off
    assign accept = start && !busy;
    assign busy   = (r_hold != '0);

    always_comb begin
        keep = !(i_point_x > r_max_x || i_point_x < r_min_x ||
                 i_point_y > r_max_y || i_point_y < r_min_y ||
                 r_max_x == r_min_x || r_max_y == r_min_y);
        n_tag.valid = accept;
        n_tag.keep  = keep;
        n_tag.last  = i_last_point;
        if (accept && keep) begin
            n_hold = HOLD_KEPT;
        end else if (r_hold != '0) begin
            n_hold = r_hold - HOLD_W'(1);
        end else begin
            n_hold = r_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
            r_tag  <= '0;
        end else begin
            r_hold <= n_hold;
            r_tag  <= n_tag;
        end
    end

    // offsets into the range and range widths, exact in 18 bits for kept points
    always_ff @(posedge i_clk) begin
        r_dx    <= DW'(i_point_x[DW-1:0] - r_min_x);
        r_dy    <= DW'(i_point_y[DW-1:0] - r_min_y);
        r_rng_x <= DW'(r_max_x - r_min_x);
        r_rng_y <= DW'(r_max_y - r_min_y);
    end

    // scale by the screen size to form the dividends
    assign tag_c[0]   = r_tag;
    assign rem_x_c[0] = NW'(r_dx) * NW'(SCREEN_MAX);
    assign rem_y_c[0] = NW'(r_dy) * NW'(SCREEN_MAX);
    assign div_x_c[0] = r_rng_x;
    assign div_y_c[0] = r_rng_y;
    assign quo_x_c[0] = '0;
    assign quo_y_c[0] = '0;

    // divider chain, most significant quotient bit first
    for (genvar k = 0; k < QW; k++) begin : g_cell
        spmp_cell #(
            .DW  (DW),
            .QW  (QW),
            .BIT (QW - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (tag_c[k]),
            .i_rem_x (rem_x_c[k]),
            .i_rem_y (rem_y_c[k]),
            .i_div_x (div_x_c[k]),
            .i_div_y (div_y_c[k]),
            .i_quo_x (quo_x_c[k]),
            .i_quo_y (quo_y_c[k]),
            .o_tag   (tag_c[k+1]),
            .o_rem_x (rem_x_c[k+1]),
            .o_rem_y (rem_y_c[k+1]),
            .o_div_x (div_x_c[k+1]),
            .o_div_y (div_y_c[k+1]),
            .o_quo_x (quo_x_c[k+1]),
            .o_quo_y (quo_y_c[k+1])
        );
    end

    // pixel words out
    spmp_emit #(
        .SCREEN_MAX (SCREEN_MAX),
        .Y_OFFSET   (Y_OFFSET),
        .QW         (QW)
    ) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tag           (tag_c[QW]),
        .i_quo_x         (quo_x_c[QW]),
        .i_quo_y         (quo_y_c[QW]),
        .o_strobe        (o_strobe),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_valid   (o_pixel_valid),
        .o_last_of_point (o_last_of_point),
        .o_plot_done     (o_plot_done)
    );

endmodule
